[design/fcsg_pkg.sv]
// Shared types, codes and constants for the filled circle span generator.
`default_nettype none
package fcsg_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int CLIP_BITS      = 15;
    localparam int SHADE_BITS     = 7;
    localparam int CHAN_BITS      = 8;
    localparam int COLOR_BITS     = 32;
    localparam int STATUS_BITS    = 3;
    localparam int NUM_SLOTS      = 4;
    localparam int SLOT_IDX_BITS  = $clog2(NUM_SLOTS);
    localparam int REG_IDX_BITS   = 3;
    localparam int M_DATA_W       = 80;
    localparam int M_USER_W       = STATUS_BITS + 1;

    localparam logic [CLIP_BITS-1:0]  CLIP_MAX    = 15'h7FFF;
    localparam logic [SHADE_BITS-1:0] SHADE_RESET = 7'd100;
    localparam logic [CHAN_BITS-1:0]  ALPHA_MAX   = 8'hFF;

    // alpha * shade, then divide by 100 as multiply by 5243 and shift by 19
    localparam int PROD_BITS    = CHAN_BITS + SHADE_BITS;
    localparam int DIV100_BITS  = 13;
    localparam logic [DIV100_BITS-1:0] DIV100_MUL = 13'd5243;
    localparam int DIV100_SHIFT = 19;

    // midpoint decision increments
    localparam int DEC_STEP_DIAG = 5;
    localparam int DEC_STEP_AXIS = 3;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_SPAN       = 3'd0,
        ST_ACCEPTED   = 3'd1,
        ST_EMPTY      = 3'd2,
        ST_BAD_RADIUS = 3'd3,
        ST_NO_SPAN    = 3'd4,
        ST_IDLE       = 3'd5
    } status_t;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_CLIP_LEFT   = 3'd0,
        REG_CLIP_TOP    = 3'd1,
        REG_CLIP_WIDTH  = 3'd2,
        REG_CLIP_HEIGHT = 3'd3,
        REG_SCAN_ENABLE = 3'd4,
        REG_SCAN_SHADE  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [CLIP_BITS-1:0]  clip_left;
        logic [CLIP_BITS-1:0]  clip_top;
        logic [CLIP_BITS-1:0]  clip_width;
        logic [CLIP_BITS-1:0]  clip_height;
        logic                  scan_en;
        logic [SHADE_BITS-1:0] scan_shade;
    } cfg_t;

    typedef struct packed {
        logic                 circle_done;
        status_t              status;
        logic [CHAN_BITS-1:0] alpha;
        logic [CHAN_BITS-1:0] blue;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] red;
        logic [CLIP_BITS-1:0] span_row;
        logic [CLIP_BITS-1:0] span_right;
        logic [CLIP_BITS-1:0] span_left;
    } result_t;

    typedef struct packed {
        result_t [NUM_SLOTS-1:0] slot;
        logic [NUM_SLOTS-1:0]    mask;
    } batch_t;

endpackage
`default_nettype wire

[design/fcsg_cfg.sv]
// Configuration register file: clip window and scanline shading.
`default_nettype none
module fcsg_cfg (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_we,
    input  wire logic [fcsg_pkg::REG_IDX_BITS-1:0]     cfg_addr,
    input  wire logic [fcsg_pkg::CLIP_BITS-1:0]        cfg_wdata,
    output fcsg_pkg::cfg_t                             cfg,
    output logic [fcsg_pkg::SHADE_BITS-1:0]            shade_next
);

    fcsg_pkg::cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (fcsg_pkg::reg_idx_t'(cfg_addr))
                fcsg_pkg::REG_CLIP_LEFT:   cfg_next.clip_left   = cfg_wdata;
                fcsg_pkg::REG_CLIP_TOP:    cfg_next.clip_top    = cfg_wdata;
                fcsg_pkg::REG_CLIP_WIDTH:  cfg_next.clip_width  = cfg_wdata;
                fcsg_pkg::REG_CLIP_HEIGHT: cfg_next.clip_height = cfg_wdata;
                fcsg_pkg::REG_SCAN_ENABLE: cfg_next.scan_en     = cfg_wdata[0];
                fcsg_pkg::REG_SCAN_SHADE:
                    cfg_next.scan_shade = cfg_wdata[fcsg_pkg::SHADE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg            <= '0;
            cfg_reg.scan_shade <= fcsg_pkg::SHADE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg        = cfg_reg;
    assign shade_next = cfg_next.scan_shade;

endmodule
`default_nettype wire

[design/fcsg_core.sv]
// Input register, circle state and single-pass start and midpoint step logic.
`default_nettype none
module fcsg_core #(
    parameter int COORD_BITS = fcsg_pkg::COORD_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic                                s_kind,
    input  wire logic signed [COORD_BITS-1:0]        s_center_x,
    input  wire logic signed [COORD_BITS-1:0]        s_center_y,
    input  wire logic signed [COORD_BITS-1:0]        s_radius,
    input  wire logic [fcsg_pkg::COLOR_BITS-1:0]     s_color,
    input  fcsg_pkg::cfg_t                           cfg,
    input  wire logic [fcsg_pkg::SHADE_BITS-1:0]     shade_next,
    input  wire logic                                emit_ready,
    output logic                                     batch_load,
    output fcsg_pkg::batch_t                         batch
);

    localparam int XW = ((COORD_BITS > fcsg_pkg::CLIP_BITS + 1) ?
                         COORD_BITS : fcsg_pkg::CLIP_BITS + 1) + 3;
    localparam int DW = COORD_BITS + 3;
    localparam int QW = fcsg_pkg::PROD_BITS + fcsg_pkg::DIV100_BITS;
    localparam logic signed [XW-1:0] ONE_W   = XW'(1);
    localparam logic signed [XW-1:0] DIAG_W  = XW'(fcsg_pkg::DEC_STEP_DIAG);
    localparam logic signed [XW-1:0] AXIS_W  = XW'(fcsg_pkg::DEC_STEP_AXIS);
    localparam logic signed [XW-1:0] CMAX_W  = XW'(fcsg_pkg::CLIP_MAX);

    // input register
    logic                             in_valid_reg, in_valid_next;
    logic                             kind_reg;
    logic signed [COORD_BITS-1:0]     cx_reg, cy_reg, r_reg;
    logic [fcsg_pkg::COLOR_BITS-1:0]  color_reg;

    // circle state
    logic                             busy_reg, busy_next;
    logic [COORD_BITS-1:0]            step_x_reg, step_x_next;
    logic [COORD_BITS-1:0]            step_y_reg, step_y_next;
    logic signed [DW-1:0]             dec_reg, dec_next;
    logic signed [COORD_BITS-1:0]     hcx_reg, hcx_next, hcy_reg, hcy_next;
    logic [fcsg_pkg::COLOR_BITS-1:0]  hcolor_reg, hcolor_next;
    logic [fcsg_pkg::PROD_BITS-1:0]   prod_reg, prod_next;

    logic                             load, accept;
    logic                             win_ok;
    logic signed [XW-1:0]             left_w, top_w, right_w, bottom_w;
    logic signed [XW-1:0]             right_raw, bottom_raw;
    logic signed [XW-1:0]             cx_w, cy_w, r_w;
    logic signed [XW-1:0]             x_w, y_w, kd_w, hx_w, hy_w;
    logic signed [XW-1:0]             x_n, y_n, kd_n;
    logic                             done;
    fcsg_pkg::status_t                start_st;
    logic [QW-1:0]                    quot_full;
    logic [QW-fcsg_pkg::DIV100_SHIFT-1:0] quot;
    logic [fcsg_pkg::CHAN_BITS-1:0]   shaded;
    logic signed [XW-1:0]             sp_x1 [fcsg_pkg::NUM_SLOTS];
    logic signed [XW-1:0]             sp_x2 [fcsg_pkg::NUM_SLOTS];
    logic signed [XW-1:0]             sp_row [fcsg_pkg::NUM_SLOTS];
    logic [fcsg_pkg::NUM_SLOTS-1:0]   sp_en, sp_vis;
    logic signed [XW-1:0]             cl, cr;

    assign s_tready   = !in_valid_reg || emit_ready;
    assign accept     = s_tvalid && s_tready;
    assign load       = in_valid_reg && emit_ready;
    assign batch_load = load;

    // window
    always_comb begin
        win_ok     = (cfg.clip_width != '0) && (cfg.clip_height != '0);
        left_w     = XW'(cfg.clip_left);
        top_w      = XW'(cfg.clip_top);
        right_raw  = left_w + XW'(cfg.clip_width) - ONE_W;
        bottom_raw = top_w + XW'(cfg.clip_height) - ONE_W;
        right_w    = (right_raw > CMAX_W) ? CMAX_W : right_raw;
        bottom_w   = (bottom_raw > CMAX_W) ? CMAX_W : bottom_raw;
    end

    // start checks
    always_comb begin
        cx_w = XW'(cx_reg);
        cy_w = XW'(cy_reg);
        r_w  = XW'(r_reg);
        if (!win_ok) begin
            start_st = fcsg_pkg::ST_EMPTY;
        end else if (r_w < 0) begin
            start_st = fcsg_pkg::ST_BAD_RADIUS;
        end else if ((cx_w + r_w < left_w) || (cx_w - r_w > right_w) ||
                     (cy_w + r_w < top_w) || (cy_w - r_w > bottom_w)) begin
            start_st = fcsg_pkg::ST_EMPTY;
        end else begin
            start_st = fcsg_pkg::ST_ACCEPTED;
        end
    end

    // midpoint step
    always_comb begin
        x_w  = XW'(step_x_reg);
        y_w  = XW'(step_y_reg);
        kd_w = XW'(dec_reg);
        hx_w = XW'(hcx_reg);
        hy_w = XW'(hcy_reg);
        if (kd_w >= 0) begin
            y_n  = y_w - ONE_W;
            kd_n = kd_w + ((x_w - y_n) <<< 1) + DIAG_W;
        end else begin
            y_n  = y_w;
            kd_n = kd_w + (x_w <<< 1) + AXIS_W;
        end
        x_n  = x_w + ONE_W;
        done = x_n > y_n;

        sp_x1[0] = hx_w - y_w;  sp_x2[0] = hx_w + y_w;  sp_row[0] = hy_w - x_w;
        sp_x1[1] = hx_w - y_w;  sp_x2[1] = hx_w + y_w;  sp_row[1] = hy_w + x_w;
        sp_x1[2] = hx_w - x_w;  sp_x2[2] = hx_w + x_w;  sp_row[2] = hy_w - y_w;
        sp_x1[3] = hx_w - x_w;  sp_x2[3] = hx_w + x_w;  sp_row[3] = hy_w + y_w;
        sp_en[0] = 1'b1;
        sp_en[1] = (x_w != 0);
        sp_en[2] = (kd_w >= 0) && (y_w != x_w);
        sp_en[3] = sp_en[2];
    end

    // odd row alpha
    always_comb begin
        quot_full = QW'(prod_reg) * QW'(fcsg_pkg::DIV100_MUL);
        quot      = quot_full[QW-1:fcsg_pkg::DIV100_SHIFT];
        shaded    = (quot > (QW-fcsg_pkg::DIV100_SHIFT)'(fcsg_pkg::ALPHA_MAX)) ?
                    fcsg_pkg::ALPHA_MAX : quot[fcsg_pkg::CHAN_BITS-1:0];
    end

    // result batch
    always_comb begin
        batch = '0;
        cl    = '0;
        cr    = '0;
        for (int k = 0; k < fcsg_pkg::NUM_SLOTS; k++) begin
            sp_vis[k] = sp_en[k] && win_ok &&
                        !((sp_x2[k] < left_w) || (sp_x1[k] > right_w) ||
                          (sp_row[k] < top_w) || (sp_row[k] > bottom_w));
        end
        if (kind_reg == fcsg_pkg::KIND_START) begin
            batch.slot[0].status = start_st;
            batch.mask           = fcsg_pkg::NUM_SLOTS'(1);
        end else if (!busy_reg) begin
            batch.slot[0].status = fcsg_pkg::ST_IDLE;
            batch.mask           = fcsg_pkg::NUM_SLOTS'(1);
        end else if (sp_vis == '0) begin
            batch.slot[0].status      = fcsg_pkg::ST_NO_SPAN;
            batch.slot[0].circle_done = done;
            batch.mask                = fcsg_pkg::NUM_SLOTS'(1);
        end else begin
            batch.mask = sp_vis;
            for (int k = 0; k < fcsg_pkg::NUM_SLOTS; k++) begin
                cl = (sp_x1[k] < left_w) ? left_w : sp_x1[k];
                cr = (sp_x2[k] > right_w) ? right_w : sp_x2[k];
                batch.slot[k].status      = fcsg_pkg::ST_SPAN;
                batch.slot[k].circle_done = done;
                batch.slot[k].span_left   = cl[fcsg_pkg::CLIP_BITS-1:0];
                batch.slot[k].span_right  = cr[fcsg_pkg::CLIP_BITS-1:0];
                batch.slot[k].span_row    = sp_row[k][fcsg_pkg::CLIP_BITS-1:0];
                batch.slot[k].red         = hcolor_reg[31:24];
                batch.slot[k].green       = hcolor_reg[23:16];
                batch.slot[k].blue        = hcolor_reg[15:8];
                batch.slot[k].alpha       = (cfg.scan_en && sp_row[k][0]) ?
                                            shaded : hcolor_reg[7:0];
            end
        end
    end

    // state update
    always_comb begin
        in_valid_next = s_tready ? s_tvalid : in_valid_reg;
        busy_next     = busy_reg;
        step_x_next   = step_x_reg;
        step_y_next   = step_y_reg;
        dec_next      = dec_reg;
        hcx_next      = hcx_reg;
        hcy_next      = hcy_reg;
        hcolor_next   = hcolor_reg;
        if (load) begin
            if (kind_reg == fcsg_pkg::KIND_START) begin
                busy_next = (start_st == fcsg_pkg::ST_ACCEPTED);
                if (start_st == fcsg_pkg::ST_ACCEPTED) begin
                    hcx_next    = cx_reg;
                    hcy_next    = cy_reg;
                    hcolor_next = color_reg;
                    step_x_next = '0;
                    step_y_next = r_reg;
                    dec_next    = DW'(ONE_W - r_w);
                end
            end else if (busy_reg) begin
                busy_next   = !done;
                step_x_next = x_n[COORD_BITS-1:0];
                step_y_next = y_n[COORD_BITS-1:0];
                dec_next    = kd_n[DW-1:0];
            end
        end
        prod_next = fcsg_pkg::PROD_BITS'(hcolor_next[7:0]) *
                    fcsg_pkg::PROD_BITS'(shade_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            busy_reg     <= 1'b0;
            step_x_reg   <= '0;
            step_y_reg   <= '0;
            dec_reg      <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            busy_reg     <= busy_next;
            step_x_reg   <= step_x_next;
            step_y_reg   <= step_y_next;
            dec_reg      <= dec_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg  <= s_kind;
            cx_reg    <= s_center_x;
            cy_reg    <= s_center_y;
            r_reg     <= s_radius;
            color_reg <= s_color;
        end
        hcx_reg    <= hcx_next;
        hcy_reg    <= hcy_next;
        hcolor_reg <= hcolor_next;
        prod_reg   <= prod_next;
    end

endmodule
`default_nettype wire

[design/fcsg_emit.sv]
// Result buffer: holds one batch of up to four results and sends them in order.
`default_nettype none
module fcsg_emit (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            batch_load,
    input  fcsg_pkg::batch_t     batch,
    output logic                 emit_ready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output fcsg_pkg::result_t    m_result,
    output logic                 m_last
);

    fcsg_pkg::result_t [fcsg_pkg::NUM_SLOTS-1:0] slot_reg;
    logic [fcsg_pkg::NUM_SLOTS-1:0] mask_reg, mask_next;
    logic [fcsg_pkg::NUM_SLOTS-1:0] sel, rest, mask_after;
    logic [fcsg_pkg::SLOT_IDX_BITS-1:0] idx;
    logic pop;

    always_comb begin
        idx = '0;
        for (int k = fcsg_pkg::NUM_SLOTS - 1; k >= 0; k--) begin
            if (mask_reg[k]) begin
                idx = fcsg_pkg::SLOT_IDX_BITS'(k);
            end
        end
        sel        = mask_reg & (~mask_reg + fcsg_pkg::NUM_SLOTS'(1));
        rest       = mask_reg & ~sel;
        m_tvalid   = (mask_reg != '0);
        pop        = m_tvalid && m_tready;
        mask_after = pop ? rest : mask_reg;
        emit_ready = (mask_after == '0);
        mask_next  = batch_load ? batch.mask : mask_after;
        m_result   = slot_reg[idx];
        m_last     = (rest == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (batch_load) begin
            slot_reg <= batch.slot;
        end
    end

endmodule
`default_nettype wire

[design/filled_circle_span_generator.sv]
// Top level of the filled circle span generator.
//
//  channel  direction  handshake            payload
//  s_       in         s_tvalid / s_tready  tuser kind; tdata center_x, center_y, radius, colour
//  m_       out        m_tvalid / m_tready  tuser status, circle_done; tdata span; tlast
//  cfg_     in         cfg_we               cfg_addr register index, cfg_wdata value
//
//  A start item or an idle step gives one result; a circle step gives one to four.
//  An item waits in the input register until the result buffer is free, then its
//  results leave the result buffer at one per cycle while m_tready is high.
//  The next item is taken in the cycle the last result of the previous one goes out.
//  Reset is synchronous on aresetn low and drops any item in flight.
//  m_tready low holds the result buffer and, through it, the input register.
`default_nettype none
module filled_circle_span_generator #(
    parameter int COORD_BITS = fcsg_pkg::COORD_BITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // center_x, center_y, radius, fill_color, then zero padding
    input  wire logic [((3*COORD_BITS+fcsg_pkg::COLOR_BITS+7)/8)*8-1:0] s_tdata,
    // kind
    input  wire logic                                   s_tuser,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // span_left, span_right, span_row, red, green, blue, alpha, zero padding
    output logic [fcsg_pkg::M_DATA_W-1:0]               m_tdata,
    // status, circle_done
    output logic [fcsg_pkg::M_USER_W-1:0]               m_tuser,
    output logic                                        m_tlast,
    input  wire logic                                   cfg_we,
    input  wire logic [fcsg_pkg::REG_IDX_BITS-1:0]      cfg_addr,
    input  wire logic [fcsg_pkg::CLIP_BITS-1:0]         cfg_wdata
);

    localparam int PAY_BITS = 3 * fcsg_pkg::CLIP_BITS + 4 * fcsg_pkg::CHAN_BITS;

    fcsg_pkg::cfg_t                   cfg;
    logic [fcsg_pkg::SHADE_BITS-1:0]  shade_next;
    logic                             emit_ready;
    logic                             batch_load;
    fcsg_pkg::batch_t                 batch;
    fcsg_pkg::result_t                m_result;

    fcsg_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .cfg        (cfg),
        .shade_next (shade_next)
    );

    fcsg_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_kind     (s_tuser),
        .s_center_x (s_tdata[COORD_BITS-1:0]),
        .s_center_y (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .s_radius   (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .s_color    (s_tdata[3*COORD_BITS+fcsg_pkg::COLOR_BITS-1:3*COORD_BITS]),
        .cfg        (cfg),
        .shade_next (shade_next),
        .emit_ready (emit_ready),
        .batch_load (batch_load),
        .batch      (batch)
    );

    fcsg_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .batch_load (batch_load),
        .batch      (batch),
        .emit_ready (emit_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_result   (m_result),
        .m_last     (m_tlast)
    );

    assign m_tdata = {(fcsg_pkg::M_DATA_W - PAY_BITS)'(0),
                      m_result.alpha, m_result.blue, m_result.green, m_result.red,
                      m_result.span_row, m_result.span_right, m_result.span_left};
    assign m_tuser = {m_result.circle_done, m_result.status};

endmodule
`default_nettype wire

[design/fcsg_checker.sv]
// Port checker for the filled circle span generator, bound to the top level.
`default_nettype none
module fcsg_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [fcsg_pkg::M_DATA_W-1:0]   m_tdata,
    input wire logic [fcsg_pkg::M_USER_W-1:0]   m_tuser,
    input wire logic                            m_tlast
);

    logic is_span;
    assign is_span = (m_tuser[fcsg_pkg::STATUS_BITS-1:0] == fcsg_pkg::ST_SPAN);

    a_no_valid_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    a_status_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !is_span |-> m_tlast && (m_tdata == '0))
        else $error("status result not lone or carries span data");

    a_span_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && is_span |->
            m_tdata[fcsg_pkg::CLIP_BITS-1:0] <= m_tdata[2*fcsg_pkg::CLIP_BITS-1:fcsg_pkg::CLIP_BITS])
        else $error("span left beyond span right");

    a_done_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tuser[fcsg_pkg::STATUS_BITS]
            == $past(m_tuser[fcsg_pkg::STATUS_BITS])))
        else $error("circle_done differs within one item's results");

endmodule

bind filled_circle_span_generator fcsg_checker u_fcsg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
